/* rtl/plct_pkg.sv */
// Shared types and codes for the piecewise-linear curve table.
`default_nettype none
package plct_pkg;

    // Default table depth
    localparam int MAX_POINTS_DEF = 16;

    // Operation codes
    localparam logic [2:0] OP_EVAL     = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_INS_SAMP = 3'd2;
    localparam logic [2:0] OP_REMOVE   = 3'd3;
    localparam logic [2:0] OP_REPLACE  = 3'd4;
    localparam logic [2:0] OP_SHIFT    = 3'd5;

    // Status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_LOST      = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] point_x;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
    } plct_in_t;

    typedef struct packed {
        logic signed [31:0] curve_value;
        logic [2:0]         status;
        logic [4:0]         point_count;
    } plct_out_t;

endpackage
`default_nettype wire

/* rtl/plct_div.sv */
// Serial restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module plct_div
    import plct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] div_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        fits;

    // Trial subtract of the divisor from the shifted remainder
    assign trial = {rem_reg, low_reg[31]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            low_reg  <= '0;
            div_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // High half is below the divisor, so the quotient fits 32 bits
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= dividend[63:32];
                low_reg  <= dividend[31:0];
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (fits)
                    rem_reg <= 32'(trial - {1'b0, div_reg});
                else
                    rem_reg <= trial[31:0];
                low_reg <= {low_reg[30:0], fits};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule
`default_nettype wire

/* rtl/piecewise_linear_curve_table_unit.sv */
// Top level of the piecewise-linear curve table unit.
//
// Usage: one input item (op, point_x, value_a, value_b) is taken on in_valid/in_ready
// and produces exactly one result item (curve_value, status, point_count) on
// out_valid/out_ready. The breakpoints sit in a small memory with one read and one
// write port, and a sequencer walks it one entry at a time, with a read and a compare state.
// Work per item: a key scan over the N breakpoints held, plus a move of each entry
// shifted by an insert or a remove (a replace or shift scans twice), plus a run
// through the serial 32-step divider when an interpolation is needed.
// One item is worked at a time; in_ready is high only while the sequencer is idle.
// A finished result sits in the output register; while the receiver stalls the
// sequencer holds until that register frees, and the next item is taken after.
// Reset empties the table (count to zero) and drops any result not yet taken;
// breakpoint storage itself is not cleared, only entries below the count are read.
`default_nettype none
module piecewise_linear_curve_table_unit
    import plct_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire plct_in_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output plct_out_t out_data
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_DIV_WAIT,
        S_INS_RD,
        S_INS_SH,
        S_INS_WR,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] ins_y_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      hit_idx_reg;
    logic               hit_reg;
    logic signed [31:0] hit_x_reg;
    logic signed [31:0] hit_y_reg;
    logic signed [31:0] lo_x_reg;
    logic signed [31:0] lo_y_reg;
    logic signed [31:0] hi_x_reg;
    logic signed [31:0] hi_y_reg;
    logic               hi_seen_reg;
    logic               moved_reg;
    logic [31:0]        t_reg;
    logic [31:0]        d_reg;
    logic [31:0]        m_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic signed [31:0] res_value_reg;
    logic [2:0]         res_status_reg;
    plct_out_t          out_reg;
    logic               out_valid_reg;

    // Breakpoint memory
    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] rd_x_reg;
    logic signed [31:0] rd_y_reg;
    logic               mem_re;
    logic               mem_we;
    logic [IW-1:0]      mem_ra;
    logic [IW-1:0]      mem_wa;
    logic signed [31:0] mem_wx;
    logic signed [31:0] mem_wy;

    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] count_dec;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_q;

    // Arithmetic helpers
    logic [32:0] sum_x;
    logic [32:0] sum_y;
    logic signed [31:0] sat_x;
    logic signed [31:0] sat_y;
    logic [32:0] diff_t;
    logic [32:0] diff_d;
    logic [32:0] diff_y;
    logic [32:0] abs_y;
    logic [32:0] interp;
    logic [31:0] count_wide;

    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);

    // Saturated move target for a shift
    assign sum_x = {hit_x_reg[31], hit_x_reg} + {a_reg[31], a_reg};
    assign sum_y = {hit_y_reg[31], hit_y_reg} + {b_reg[31], b_reg};
    assign sat_x = (sum_x[32] != sum_x[31]) ? (sum_x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                            : sum_x[31:0];
    assign sat_y = (sum_y[32] != sum_y[31]) ? (sum_y[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                            : sum_y[31:0];

    // Interpolation operands
    assign diff_t = {key_reg[31], key_reg} - {lo_x_reg[31], lo_x_reg};
    assign diff_d = {hi_x_reg[31], hi_x_reg} - {lo_x_reg[31], lo_x_reg};
    assign diff_y = {hi_y_reg[31], hi_y_reg} - {lo_y_reg[31], lo_y_reg};
    assign abs_y  = diff_y[32] ? (33'd0 - diff_y) : diff_y;
    assign interp = neg_reg ? ({lo_y_reg[31], lo_y_reg} - {1'b0, div_q})
                            : ({lo_y_reg[31], lo_y_reg} + {1'b0, div_q});

    plct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = (state_reg == S_DIV);

    // Memory port control
    always_comb
    begin
        mem_re = 1'b0;
        mem_we = 1'b0;
        mem_ra = idx_reg[IW-1:0];
        mem_wa = idx_reg[IW-1:0];
        mem_wx = rd_x_reg;
        mem_wy = rd_y_reg;
        case (state_reg)
            S_SCAN_RD: mem_re = (idx_reg != count_reg);
            S_INS_RD:
            begin
                mem_re = (idx_reg != pos_reg);
                mem_ra = idx_dec[IW-1:0];
            end
            S_INS_SH:  mem_we = 1'b1;
            S_INS_WR:
            begin
                mem_we = 1'b1;
                mem_wa = pos_reg[IW-1:0];
                mem_wx = key_reg;
                mem_wy = ins_y_reg;
            end
            S_RM_RD:
            begin
                mem_re = (idx_inc < count_reg);
                mem_ra = idx_inc[IW-1:0];
            end
            S_RM_WR:   mem_we = 1'b1;
            default:   mem_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[mem_wa] <= mem_wx;
            mem_y[mem_wa] <= mem_wy;
        end
        if (mem_re)
        begin
            rd_x_reg <= mem_x[mem_ra];
            rd_y_reg <= mem_y[mem_ra];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            ins_y_reg      <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            hit_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_x_reg      <= '0;
            hit_y_reg      <= '0;
            lo_x_reg       <= '0;
            lo_y_reg       <= '0;
            hi_x_reg       <= '0;
            hi_y_reg       <= '0;
            hi_seen_reg    <= 1'b0;
            moved_reg      <= 1'b0;
            t_reg          <= '0;
            d_reg          <= '0;
            m_reg          <= '0;
            neg_reg        <= 1'b0;
            prod_reg       <= '0;
            res_value_reg  <= '0;
            res_status_reg <= ST_DONE;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // S_DONE refills the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= in_data.op;
                        key_reg        <= in_data.point_x;
                        a_reg          <= in_data.value_a;
                        b_reg          <= in_data.value_b;
                        ins_y_reg      <= in_data.value_a;
                        res_value_reg  <= '0;
                        res_status_reg <= ST_DONE;
                        moved_reg      <= 1'b0;
                        idx_reg        <= '0;
                        pos_reg        <= '0;
                        hit_reg        <= 1'b0;
                        hi_seen_reg    <= 1'b0;
                        state_reg      <= S_SCAN_RD;
                    end
                end

                // Walk the table once for the key
                S_SCAN_RD:
                begin
                    if (idx_reg == count_reg)
                        state_reg <= S_DECIDE;
                    else
                        state_reg <= S_SCAN_CMP;
                end

                S_SCAN_CMP:
                begin
                    if (rd_x_reg == key_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                        hit_x_reg   <= rd_x_reg;
                        hit_y_reg   <= rd_y_reg;
                    end
                    else if (rd_x_reg < key_reg)
                    begin
                        lo_x_reg <= rd_x_reg;
                        lo_y_reg <= rd_y_reg;
                        pos_reg  <= idx_inc;
                    end
                    else if (!hi_seen_reg)
                    begin
                        hi_seen_reg <= 1'b1;
                        hi_x_reg    <= rd_x_reg;
                        hi_y_reg    <= rd_y_reg;
                    end
                    idx_reg   <= idx_inc;
                    state_reg <= S_SCAN_RD;
                end

                S_DECIDE:
                begin
                    case (op_reg)
                        OP_EVAL: state_reg <= S_EVAL;
                        OP_INSERT, OP_INS_SAMP:
                        begin
                            if (hit_reg)
                            begin
                                res_status_reg <= ST_DUPLICATE;
                                state_reg      <= S_DONE;
                            end
                            else if (count_reg >= CW'(MAX_POINTS))
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_DONE;
                            end
                            else if (op_reg == OP_INS_SAMP)
                                state_reg <= S_EVAL;
                            else
                            begin
                                idx_reg   <= count_reg;
                                state_reg <= S_INS_RD;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_reg)
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= hit_idx_reg;
                                state_reg <= S_RM_RD;
                            end
                        end
                        OP_REPLACE, OP_SHIFT:
                        begin
                            if (!moved_reg)
                            begin
                                if (!hit_reg)
                                begin
                                    res_status_reg <= ST_NOT_FOUND;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    // Take the point out, then look up its new place
                                    key_reg   <= (op_reg == OP_SHIFT) ? sat_x : a_reg;
                                    ins_y_reg <= (op_reg == OP_SHIFT) ? sat_y : b_reg;
                                    idx_reg   <= hit_idx_reg;
                                    state_reg <= S_RM_RD;
                                end
                            end
                            else if (hit_reg)
                            begin
                                res_status_reg <= ST_LOST;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                idx_reg   <= count_reg;
                                state_reg <= S_INS_RD;
                            end
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end

                // Curve value at the key
                S_EVAL:
                begin
                    t_reg   <= diff_t[31:0];
                    d_reg   <= diff_d[31:0];
                    m_reg   <= abs_y[31:0];
                    neg_reg <= diff_y[32];
                    if (count_reg == '0)
                        ins_y_reg <= '0;
                    else if (hit_reg)
                        ins_y_reg <= hit_y_reg;
                    else if (pos_reg == '0)
                        ins_y_reg <= hi_y_reg;
                    else if (pos_reg == count_reg)
                        ins_y_reg <= lo_y_reg;
                    if ((count_reg == '0) || hit_reg || (pos_reg == '0) ||
                        (pos_reg == count_reg))
                    begin
                        if (op_reg == OP_EVAL)
                        begin
                            if (count_reg == '0)
                                res_value_reg <= '0;
                            else if (hit_reg)
                                res_value_reg <= hit_y_reg;
                            else if (pos_reg == '0)
                                res_value_reg <= hi_y_reg;
                            else
                                res_value_reg <= lo_y_reg;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= count_reg;
                            state_reg <= S_INS_RD;
                        end
                    end
                    else
                        state_reg <= S_MUL;
                end

                S_MUL:
                begin
                    prod_reg  <= t_reg * m_reg;
                    state_reg <= S_DIV;
                end

                S_DIV: state_reg <= S_DIV_WAIT;

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (op_reg == OP_EVAL)
                        begin
                            res_value_reg <= interp[31:0];
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            ins_y_reg <= interp[31:0];
                            idx_reg   <= count_reg;
                            state_reg <= S_INS_RD;
                        end
                    end
                end

                // Open a slot at the insert position, top entry first
                S_INS_RD:
                begin
                    if (idx_reg == pos_reg)
                        state_reg <= S_INS_WR;
                    else
                        state_reg <= S_INS_SH;
                end

                S_INS_SH:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_INS_RD;
                end

                S_INS_WR:
                begin
                    count_reg <= count_inc;
                    state_reg <= S_DONE;
                end

                // Close the gap left by a removed entry
                S_RM_RD:
                begin
                    if (idx_inc < count_reg)
                        state_reg <= S_RM_WR;
                    else
                    begin
                        count_reg <= count_dec;
                        if ((op_reg == OP_REPLACE) || (op_reg == OP_SHIFT))
                        begin
                            moved_reg   <= 1'b1;
                            idx_reg     <= '0;
                            pos_reg     <= '0;
                            hit_reg     <= 1'b0;
                            hi_seen_reg <= 1'b0;
                            state_reg   <= S_SCAN_RD;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end

                S_RM_WR:
                begin
                    idx_reg   <= idx_inc;
                    state_reg <= S_RM_RD;
                end

                // Hand the result to the output register once it is free
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.curve_value <= res_value_reg;
                        out_reg.status      <= res_status_reg;
                        out_reg.point_count <= count_wide[4:0];
                        out_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign count_wide = 32'(count_reg);
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

endmodule
`default_nettype wire
